// ===== src/scd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants for the scanline display controller.
// ----------------------------------------------------------------------------
package scd_pkg;

  // Command codes on the input channel.
  localparam logic [2:0] CMD_FIFO_WR   = 3'd0;
  localparam logic [2:0] CMD_CTRL_WR   = 3'd1;
  localparam logic [2:0] CMD_BORDER_WR = 3'd2;
  localparam logic [2:0] CMD_RETRACE   = 3'd3;
  localparam logic [2:0] CMD_SYNC      = 3'd4;
  localparam logic [2:0] CMD_RESET     = 3'd5;

  // Slot source codes.
  localparam logic [1:0] SRC_ZERO    = 2'd0;
  localparam logic [1:0] SRC_PATTERN = 2'd1;
  localparam logic [1:0] SRC_MEMORY  = 2'd2;

  // Control register bits.
  localparam int CTRL_DISPLAY_ON = 0;
  localparam int CTRL_BLANK      = 1;
  localparam int CTRL_PICTURE    = 2;
  localparam int CTRL_INVERT     = 3;
  localparam int CTRL_ODD_FIELD  = 4;
  localparam int CTRL_SYNC       = 5;
  localparam int CTRL_KEEP_FIFO  = 6;

  // Scanline geometry.
  localparam int          PICTURE_WORDS = 64;
  localparam logic [5:0]  SLOT_LAST     = 6'd63;
  localparam logic [11:0] LINE_OFS_ODD  = 12'd37;
  localparam logic [11:0] LINE_OFS_EVEN = 12'd36;
  localparam logic [11:0] DRAW_LINE_END = 12'd860;
  localparam logic [11:0] LINE_SAT      = 12'd4093;
  localparam logic [11:0] LINE_MAX      = 12'd4095;
  localparam logic [11:0] LINE_STEP     = 12'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FIFO_WR,
    OP_CTRL_WR,
    OP_BORDER_WR,
    OP_RETRACE,
    OP_SYNC,
    OP_RESET
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] data;
  } cmd_item_t;

  typedef enum logic {
    BK_IDLE,
    BK_SLOTS
  } back_state_t;

endpackage
`default_nettype wire

// ===== src/scd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_front
// Accepts input transfers, decodes the command and queues it for the back end.
// ----------------------------------------------------------------------------
module scd_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_cmd,
  input  wire logic [15:0]        in_data,
  output logic                    q_valid,
  output scd_pkg::cmd_item_t      q_item,
  input  wire logic               q_pop
);

  scd_pkg::cmd_item_t q_mem_r [2];
  logic               wr_ptr_r, wr_ptr_nxt;
  logic               rd_ptr_r, rd_ptr_nxt;
  logic [1:0]         count_r, count_nxt;
  scd_pkg::cmd_item_t dec_item;
  logic               push;
  logic               pop;

  always_comb begin
    dec_item.data = in_data;
    unique case (in_cmd)
      scd_pkg::CMD_FIFO_WR:   dec_item.op = scd_pkg::OP_FIFO_WR;
      scd_pkg::CMD_CTRL_WR:   dec_item.op = scd_pkg::OP_CTRL_WR;
      scd_pkg::CMD_BORDER_WR: dec_item.op = scd_pkg::OP_BORDER_WR;
      scd_pkg::CMD_RETRACE:   dec_item.op = scd_pkg::OP_RETRACE;
      scd_pkg::CMD_SYNC:      dec_item.op = scd_pkg::OP_SYNC;
      scd_pkg::CMD_RESET:     dec_item.op = scd_pkg::OP_RESET;
      default:                dec_item.op = scd_pkg::OP_NOP;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule
`default_nettype wire

// ===== src/scd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scd_back
// Executes queued commands: register state, the segment FIFO, the slot
// sequencer for retrace lines and the output register.
// ----------------------------------------------------------------------------
module scd_back #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire scd_pkg::cmd_item_t  q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [5:0]               out_slot,
  output logic [1:0]               out_slot_source,
  output logic [15:0]              out_fetch_address,
  output logic [15:0]              out_border_word,
  output logic                     out_draw_enable,
  output logic [9:0]               out_draw_line,
  output logic                     out_invert_out,
  output logic                     out_wake_task,
  output logic                     out_sleep_task,
  output logic                     out_clear_screen,
  output logic                     out_fifo_overflow,
  output logic                     out_last
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  // Segment FIFO storage.
  logic [15:0]      seg_mem [FIFO_DEPTH];
  logic [15:0]      rd_data_r;
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [SUM_W-1:0] tail_sum;
  logic [SUM_W-1:0] tail_wrap;

  scd_pkg::back_state_t state_r, state_nxt;

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             display_on_r, display_on_nxt;
  logic             blank_r, blank_nxt;
  logic             picture_r, picture_nxt;
  logic             invert_r, invert_nxt;
  logic             odd_r, odd_nxt;
  logic [15:0]      border_r, border_nxt;
  logic [11:0]      line_cnt_r, line_cnt_nxt;
  logic             sync_r, sync_nxt;

  // Per-line values latched at retrace start.
  logic [5:0]       slot_r, slot_nxt;
  logic [1:0]       src_r, src_nxt;
  logic [5:0]       seg_last_r, seg_last_nxt;
  logic [9:0]       seg_line_r, seg_line_nxt;
  logic [15:0]      pword_r, pword_nxt;
  logic             den_r, den_nxt;
  logic [9:0]       dline_r, dline_nxt;
  logic             line_inv_r, line_inv_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [5:0]       o_slot_r, o_slot_nxt;
  logic [1:0]       o_src_r, o_src_nxt;
  logic [15:0]      o_addr_r, o_addr_nxt;
  logic [15:0]      o_border_r, o_border_nxt;
  logic             o_den_r, o_den_nxt;
  logic [9:0]       o_dline_r, o_dline_nxt;
  logic             o_inv_r, o_inv_nxt;
  logic             o_wake_r, o_wake_nxt;
  logic             o_sleep_r, o_sleep_nxt;
  logic             o_clear_r, o_clear_nxt;
  logic             o_ovf_r, o_ovf_nxt;
  logic             o_last_r, o_last_nxt;

  logic             out_free;
  logic             start;
  logic             fifo_pop;
  logic             fifo_flush;
  logic             fifo_full;
  logic [11:0]      eff;
  logic [7:0]       pbyte;

  assign out_free  = !out_valid_r || out_ready;
  assign start     = (state_r == scd_pkg::BK_IDLE) && q_valid && out_free;
  assign fifo_full = (count_r >= CNT_W'(FIFO_DEPTH));

  assign tail_sum  = SUM_W'(head_r) + SUM_W'(count_r);
  assign tail_wrap = (tail_sum >= SUM_W'(FIFO_DEPTH)) ? tail_sum - SUM_W'(FIFO_DEPTH)
                                                      : tail_sum;
  assign mem_waddr = tail_wrap[PTR_W-1:0];

  assign eff   = line_cnt_r - (odd_r ? scd_pkg::LINE_OFS_ODD : scd_pkg::LINE_OFS_EVEN);
  assign pbyte = eff[1] ? border_r[15:8] : border_r[7:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scd_pkg::BK_IDLE: begin
        if (start && q_item.op == scd_pkg::OP_RETRACE && display_on_r) begin
          state_nxt = scd_pkg::BK_SLOTS;
        end
      end
      scd_pkg::BK_SLOTS: begin
        if (out_free && slot_r == scd_pkg::SLOT_LAST) begin
          state_nxt = scd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = scd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    fifo_pop       = 1'b0;
    fifo_flush     = 1'b0;
    display_on_nxt = display_on_r;
    blank_nxt      = blank_r;
    picture_nxt    = picture_r;
    invert_nxt     = invert_r;
    odd_nxt        = odd_r;
    border_nxt     = border_r;
    line_cnt_nxt   = line_cnt_r;
    sync_nxt       = sync_r;
    slot_nxt       = slot_r;
    src_nxt        = src_r;
    seg_last_nxt   = seg_last_r;
    seg_line_nxt   = seg_line_r;
    pword_nxt      = pword_r;
    den_nxt        = den_r;
    dline_nxt      = dline_r;
    line_inv_nxt   = line_inv_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    o_slot_nxt     = o_slot_r;
    o_src_nxt      = o_src_r;
    o_addr_nxt     = o_addr_r;
    o_border_nxt   = o_border_r;
    o_den_nxt      = o_den_r;
    o_dline_nxt    = o_dline_r;
    o_inv_nxt      = o_inv_r;
    o_wake_nxt     = o_wake_r;
    o_sleep_nxt    = o_sleep_r;
    o_clear_nxt    = o_clear_r;
    o_ovf_nxt      = o_ovf_r;
    o_last_nxt     = o_last_r;

    if (state_r == scd_pkg::BK_SLOTS) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        o_slot_nxt    = slot_r;
        o_src_nxt     = src_r;
        o_addr_nxt    = (src_r == scd_pkg::SRC_MEMORY) ? {seg_line_r, slot_r} : 16'd0;
        o_border_nxt  = pword_r;
        o_den_nxt     = den_r;
        o_dline_nxt   = dline_r;
        o_inv_nxt     = line_inv_r;
        o_wake_nxt    = (slot_r == scd_pkg::SLOT_LAST);
        o_sleep_nxt   = 1'b0;
        o_clear_nxt   = 1'b0;
        o_ovf_nxt     = 1'b0;
        o_last_nxt    = (slot_r == scd_pkg::SLOT_LAST);
        slot_nxt      = slot_r + 6'd1;
        // The next segment takes over after the current one's last slot.
        if (src_r == scd_pkg::SRC_MEMORY && slot_r != scd_pkg::SLOT_LAST &&
            slot_r == seg_last_r && count_r != '0) begin
          fifo_pop     = 1'b1;
          seg_last_nxt = rd_data_r[15:10];
          seg_line_nxt = rd_data_r[9:0];
        end
      end
    end else if (start) begin
      q_pop = 1'b1;
      if (q_item.op == scd_pkg::OP_RETRACE && display_on_r) begin
        slot_nxt     = 6'd0;
        den_nxt      = (eff >= 12'd1) && (eff < scd_pkg::DRAW_LINE_END);
        dline_nxt    = ((eff >= 12'd1) && (eff < scd_pkg::DRAW_LINE_END)) ? eff[9:0] : 10'd0;
        pword_nxt    = blank_r ? 16'd0 : {pbyte, pbyte};
        line_inv_nxt = invert_r;
        if (blank_r) begin
          src_nxt = scd_pkg::SRC_ZERO;
        end else if (!picture_r) begin
          src_nxt = scd_pkg::SRC_PATTERN;
        end else if (count_r == '0) begin
          src_nxt = scd_pkg::SRC_ZERO;
        end else begin
          src_nxt      = scd_pkg::SRC_MEMORY;
          fifo_pop     = 1'b1;
          seg_last_nxt = rd_data_r[15:10];
          seg_line_nxt = rd_data_r[9:0];
        end
        line_cnt_nxt = (line_cnt_r >= scd_pkg::LINE_SAT) ? scd_pkg::LINE_MAX
                                                         : line_cnt_r + scd_pkg::LINE_STEP;
      end else begin
        out_valid_nxt = 1'b1;
        o_slot_nxt    = 6'd0;
        o_src_nxt     = scd_pkg::SRC_ZERO;
        o_addr_nxt    = 16'd0;
        o_border_nxt  = 16'd0;
        o_den_nxt     = 1'b0;
        o_dline_nxt   = 10'd0;
        o_inv_nxt     = 1'b0;
        o_wake_nxt    = 1'b0;
        o_sleep_nxt   = 1'b0;
        o_clear_nxt   = 1'b0;
        o_ovf_nxt     = 1'b0;
        o_last_nxt    = 1'b1;
        case (q_item.op)
          scd_pkg::OP_FIFO_WR: begin
            if (fifo_full) begin
              o_ovf_nxt = 1'b1;
            end else begin
              mem_we = 1'b1;
            end
          end
          scd_pkg::OP_CTRL_WR: begin
            display_on_nxt = q_item.data[scd_pkg::CTRL_DISPLAY_ON];
            blank_nxt      = q_item.data[scd_pkg::CTRL_BLANK];
            picture_nxt    = q_item.data[scd_pkg::CTRL_PICTURE];
            invert_nxt     = q_item.data[scd_pkg::CTRL_INVERT];
            if (q_item.data[scd_pkg::CTRL_SYNC]) begin
              line_cnt_nxt = 12'd0;
              odd_nxt      = q_item.data[scd_pkg::CTRL_ODD_FIELD];
              sync_nxt     = 1'b1;
            end
            fifo_flush  = !q_item.data[scd_pkg::CTRL_KEEP_FIFO];
            o_sleep_nxt = !q_item.data[scd_pkg::CTRL_DISPLAY_ON];
          end
          scd_pkg::OP_BORDER_WR: begin
            border_nxt = q_item.data;
          end
          scd_pkg::OP_SYNC: begin
            o_clear_nxt = !sync_r;
            sync_nxt    = 1'b0;
          end
          scd_pkg::OP_RESET: begin
            display_on_nxt = 1'b0;
            blank_nxt      = 1'b0;
            picture_nxt    = 1'b0;
            invert_nxt     = 1'b0;
            odd_nxt        = 1'b0;
            line_cnt_nxt   = 12'd0;
            fifo_flush     = 1'b1;
            o_clear_nxt    = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    // FIFO pointer bookkeeping.
    head_nxt  = head_r;
    count_nxt = count_r;
    if (fifo_flush) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (fifo_pop) begin
      head_nxt  = (head_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
      count_nxt = count_r - CNT_W'(1);
    end else if (mem_we) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  // The read register always holds the word at the head; a write to that
  // address in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[mem_waddr] <= q_item.data;
    end
    if (mem_we && mem_waddr == head_nxt) begin
      rd_data_r <= q_item.data;
    end else begin
      rd_data_r <= seg_mem[head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scd_pkg::BK_IDLE;
      head_r       <= '0;
      count_r      <= '0;
      display_on_r <= 1'b0;
      blank_r      <= 1'b0;
      picture_r    <= 1'b0;
      invert_r     <= 1'b0;
      odd_r        <= 1'b0;
      border_r     <= 16'd0;
      line_cnt_r   <= 12'd0;
      sync_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      count_r      <= count_nxt;
      display_on_r <= display_on_nxt;
      blank_r      <= blank_nxt;
      picture_r    <= picture_nxt;
      invert_r     <= invert_nxt;
      odd_r        <= odd_nxt;
      border_r     <= border_nxt;
      line_cnt_r   <= line_cnt_nxt;
      sync_r       <= sync_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    src_r      <= src_nxt;
    seg_last_r <= seg_last_nxt;
    seg_line_r <= seg_line_nxt;
    pword_r    <= pword_nxt;
    den_r      <= den_nxt;
    dline_r    <= dline_nxt;
    line_inv_r <= line_inv_nxt;
    o_slot_r   <= o_slot_nxt;
    o_src_r    <= o_src_nxt;
    o_addr_r   <= o_addr_nxt;
    o_border_r <= o_border_nxt;
    o_den_r    <= o_den_nxt;
    o_dline_r  <= o_dline_nxt;
    o_inv_r    <= o_inv_nxt;
    o_wake_r   <= o_wake_nxt;
    o_sleep_r  <= o_sleep_nxt;
    o_clear_r  <= o_clear_nxt;
    o_ovf_r    <= o_ovf_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_slot          = o_slot_r;
  assign out_slot_source   = o_src_r;
  assign out_fetch_address = o_addr_r;
  assign out_border_word   = o_border_r;
  assign out_draw_enable   = o_den_r;
  assign out_draw_line     = o_dline_r;
  assign out_invert_out    = o_inv_r;
  assign out_wake_task     = o_wake_r;
  assign out_sleep_task    = o_sleep_r;
  assign out_clear_screen  = o_clear_r;
  assign out_fifo_overflow = o_ovf_r;
  assign out_last          = o_last_r;

endmodule
`default_nettype wire

// ===== src/scanline_display_controller_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scanline_display_controller_unit
// Display controller that turns bus writes and line ticks into per-slot
// fetch descriptors for one scanline.
// ----------------------------------------------------------------------------
// A two-entry command queue decouples input transfers from execution. Register
// writes, sync checks, resets and retraces with the display off each give one
// result. A retrace with the display on latches the line setup, pops the first
// queued segment in picture mode, then gives one result per picture slot, 64
// results in all, with the slot sequencer and its single output register setting
// the pace and stalling while the output is not taken. The segment FIFO is a FIFO_DEPTH
// word memory with a registered read port that always presents the head word.
module scanline_display_controller_unit #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_slot,
  output logic [1:0]       out_slot_source,
  output logic [15:0]      out_fetch_address,
  output logic [15:0]      out_border_word,
  output logic             out_draw_enable,
  output logic [9:0]       out_draw_line,
  output logic             out_invert_out,
  output logic             out_wake_task,
  output logic             out_sleep_task,
  output logic             out_clear_screen,
  output logic             out_fifo_overflow,
  output logic             out_last
);

  logic               q_valid;
  scd_pkg::cmd_item_t q_item;
  logic               q_pop;

  scd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  scd_back #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_slot          (out_slot),
    .out_slot_source   (out_slot_source),
    .out_fetch_address (out_fetch_address),
    .out_border_word   (out_border_word),
    .out_draw_enable   (out_draw_enable),
    .out_draw_line     (out_draw_line),
    .out_invert_out    (out_invert_out),
    .out_wake_task     (out_wake_task),
    .out_sleep_task    (out_sleep_task),
    .out_clear_screen  (out_clear_screen),
    .out_fifo_overflow (out_fifo_overflow),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire
